>>> design/vca_pkg.sv
// Shared types and constants of the voice channel allocator.
// Used by vca_regs, vca_cell and voice_channel_allocator; no dependencies.
package vca_pkg;

    localparam int CHANNELS        = 16;
    localparam int TONE_BASE       = 12;
    localparam int SAMPLE_CHANNELS = 12;
    localparam int TRACK_COUNT     = 16;
    localparam logic [7:0] PRIO_MAX     = 8'hFF;
    localparam logic [3:0] ACTIVE_RESET = 4'd8;
    localparam logic       TONE_RESET   = 1'b1;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_REL   = 2'd1;
    localparam logic [1:0] REQ_FREE  = 2'd2;

    localparam logic REG_ACTIVE = 1'b0;
    localparam logic REG_TONE   = 1'b1;

    typedef enum logic [1:0] {
        ST_OFF  = 2'd0,
        ST_PLAY = 2'd1,
        ST_STOP = 2'd2
    } chan_st_t;

    typedef struct packed {
        chan_st_t   st;
        logic [7:0] pri;
        logic [3:0] own;
    } chan_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] lim;
        logic       stop_tier;
        logic       done_off;
        logic       has_pick;
        logic [3:0] pick;
        logic [7:0] bp;
        logic [3:0] bt;
    } scan_t;

    typedef struct packed {
        logic       en;
        logic [3:0] idx;
        chan_st_t   st;
        logic [7:0] pri;
        logic [3:0] own;
    } wr_t;

    typedef struct packed {
        logic [3:0] active_channels;
        logic       tone_enable;
    } cfg_t;

endpackage

>>> design/voice_channel_allocator.sv
// Voice channel allocator: sixteen channel cells in a chain plus sequencer.
// Sample allocate: the result strobe follows the start transfer once the candidate
// record, launched from a register, has walked the first min(SAMPLE_CHANNELS, 12) cells.
// Other requests: the result strobe is registered from the LOOK state. Busy drops
// with the strobe, and no request ever stalls.
// Reset: all channels off, active_channels 8, tone_enable 1.
module voice_channel_allocator #(
    parameter int SAMPLE_CHANNELS = vca_pkg::SAMPLE_CHANNELS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [3:0]  chan_sel,
    input  logic [7:0]  player_priority,
    input  logic [7:0]  track_priority,
    input  logic [3:0]  track_id,
    input  logic [2:0]  tone_type,
    output logic        done,
    output logic        granted,
    output logic [3:0]  chan_out,
    output logic        replaced_active,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import vca_pkg::*;

    localparam int SCAN_LEN = (SAMPLE_CHANNELS < TONE_BASE) ? SAMPLE_CHANNELS : TONE_BASE;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SAMPLE,
        OP_TONE,
        OP_REL,
        OP_FREE
    } op_t;

    cfg_t       cfg;
    chan_t      chans [CHANNELS];
    scan_t      chain [CHANNELS+1];
    scan_t      tap;
    chan_t      cur;
    wr_t        wr;

    state_t     state_reg;
    op_t        op_reg;
    op_t        op_next;
    logic [3:0] addr_reg;
    logic [3:0] addr_next;
    logic [7:0] prio_reg;
    logic [3:0] track_reg;
    scan_t      launch_reg;
    logic       done_reg;
    logic       granted_reg;
    logic [3:0] chan_reg;
    logic       repl_reg;

    logic [8:0] prio_sum;
    logic [7:0] prio_sat;
    logic [3:0] lim;
    logic       fin;
    logic       dec_grant;
    logic [3:0] dec_chan;
    logic       dec_repl;

    vca_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign chain[0] = launch_reg;

    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_cell
        vca_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .scan_in  (chain[i]),
            .wr       (wr),
            .scan_out (chain[i+1]),
            .chan     (chans[i])
        );
    end

    assign tap = chain[SCAN_LEN];
    assign cur = chans[addr_reg];

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign granted         = granted_reg;
    assign chan_out        = chan_reg;
    assign replaced_active = repl_reg;

    assign prio_sum = {1'b0, player_priority} + {1'b0, track_priority};
    assign prio_sat = prio_sum[8] ? PRIO_MAX : prio_sum[7:0];
    assign lim      = (cfg.active_channels > 4'(SCAN_LEN)) ? 4'(SCAN_LEN)
                                                           : cfg.active_channels;

    always_comb
    begin
        op_next   = OP_NONE;
        addr_next = chan_sel;
        unique case (req_type)
            REQ_ALLOC:
            begin
                if ({1'b0, track_id} >= 5'(TRACK_COUNT))
                    op_next = OP_NONE;
                else if (tone_type == 3'd0)
                    op_next = OP_SAMPLE;
                else if (cfg.tone_enable && (tone_type <= 3'd4))
                begin
                    op_next   = OP_TONE;
                    addr_next = 4'(TONE_BASE - 1) + {1'b0, tone_type};
                end
            end
            REQ_REL:  op_next = OP_REL;
            REQ_FREE: op_next = OP_FREE;
            default:  op_next = OP_NONE;
        endcase
    end

    always_comb
    begin
        fin       = (state_reg == S_LOOK) || ((state_reg == S_SCAN) && tap.valid);
        dec_grant = 1'b0;
        dec_chan  = 4'd0;
        dec_repl  = 1'b0;
        wr        = '{en: 1'b0, idx: addr_reg, st: ST_PLAY, pri: prio_reg, own: track_reg};
        unique case (op_reg)
            OP_SAMPLE:
            begin
                dec_grant = tap.has_pick;
                dec_chan  = tap.has_pick ? tap.pick : 4'd0;
                dec_repl  = tap.has_pick && !tap.done_off;
                wr.en     = fin && tap.has_pick;
                wr.idx    = tap.pick;
            end
            OP_TONE:
            begin
                dec_grant = !((cur.st == ST_PLAY) &&
                              ((cur.pri > prio_reg) ||
                               ((cur.pri == prio_reg) && (cur.own < track_reg))));
                dec_chan  = dec_grant ? addr_reg : 4'd0;
                dec_repl  = dec_grant && (cur.st != ST_OFF);
                wr.en     = fin && dec_grant;
            end
            OP_REL:
            begin
                dec_chan  = addr_reg;
                dec_repl  = (cur.st != ST_OFF);
                dec_grant = dec_repl;
                wr        = '{en: fin && dec_repl, idx: addr_reg, st: ST_STOP,
                              pri: cur.pri, own: cur.own};
            end
            OP_FREE:
            begin
                dec_chan  = addr_reg;
                dec_repl  = (cur.st != ST_OFF);
                dec_grant = 1'b1;
                wr        = '{en: fin, idx: addr_reg, st: ST_OFF,
                              pri: cur.pri, own: cur.own};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            op_reg      <= OP_NONE;
            addr_reg    <= 4'd0;
            prio_reg    <= 8'd0;
            track_reg   <= 4'd0;
            launch_reg  <= '0;
            done_reg    <= 1'b0;
            granted_reg <= 1'b0;
            chan_reg    <= 4'd0;
            repl_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= fin;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= op_next;
                        addr_reg  <= addr_next;
                        prio_reg  <= prio_sat;
                        track_reg <= track_id;
                        launch_reg <= '{valid: (op_next == OP_SAMPLE), lim: lim,
                                        stop_tier: 1'b0, done_off: 1'b0, has_pick: 1'b0,
                                        pick: 4'd0, bp: prio_sat, bt: track_id};
                        state_reg <= (op_next == OP_SAMPLE) ? S_SCAN : S_LOOK;
                    end
                end
                S_LOOK, S_SCAN:
                begin
                    launch_reg.valid <= 1'b0;
                    if (fin)
                    begin
                        granted_reg <= dec_grant;
                        chan_reg    <= dec_chan;
                        repl_reg    <= dec_repl;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg != S_IDLE))
        else $error("result strobe without a request in flight");

    a_repl_needs_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !granted_reg) |-> !repl_reg)
        else $error("replaced_active set on a refused request");

    a_alloc_plays: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && granted_reg && ((op_reg == OP_SAMPLE) || (op_reg == OP_TONE)))
        |-> (chans[chan_reg].st == ST_PLAY))
        else $error("allocated channel is not playing");

    a_tap_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tap.valid |-> (state_reg == S_SCAN))
        else $error("scan record arrived outside the scan");

endmodule

>>> design/vca_regs.sv
// Configuration registers behind the APB-style port.
// Depends on vca_pkg.
module vca_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output vca_pkg::cfg_t cfg
);
    import vca_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_channels <= ACTIVE_RESET;
            cfg_reg.tone_enable     <= TONE_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_ACTIVE: cfg_reg.active_channels <= pwdata[3:0];
                REG_TONE:   cfg_reg.tone_enable     <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ACTIVE: prdata = {28'd0, cfg_reg.active_channels};
            REG_TONE:   prdata = {31'd0, cfg_reg.tone_enable};
            default:    prdata = 32'd0;
        endcase
    end

endmodule

>>> design/vca_cell.sv
// One voice channel: holds its state, priority and owner, and folds itself
// into the candidate record passing down the chain. Depends on vca_pkg.
module vca_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  vca_pkg::scan_t scan_in,
    input  vca_pkg::wr_t   wr,
    output vca_pkg::scan_t scan_out,
    output vca_pkg::chan_t chan
);
    import vca_pkg::*;

    localparam logic [3:0] IDX = 4'(CELL_IDX);

    chan_t chan_reg;
    scan_t scan_reg;
    scan_t scan_next;
    logic  active;
    logic  beats;

    assign chan     = chan_reg;
    assign scan_out = scan_reg;
    assign active   = scan_in.valid && !scan_in.done_off && (IDX < scan_in.lim);
    assign beats    = (chan_reg.pri != scan_in.bp) ? (chan_reg.pri < scan_in.bp)
                                                   : (chan_reg.own >= scan_in.bt);

    always_comb
    begin
        scan_next = scan_in;
        if (active)
        begin
            unique case (chan_reg.st)
                ST_OFF:
                begin
                    scan_next.done_off = 1'b1;
                    scan_next.has_pick = 1'b1;
                    scan_next.pick     = IDX;
                end
                ST_STOP:
                begin
                    if (!scan_in.stop_tier || beats)
                    begin
                        scan_next.stop_tier = 1'b1;
                        scan_next.has_pick  = 1'b1;
                        scan_next.pick      = IDX;
                        scan_next.bp        = chan_reg.pri;
                        scan_next.bt        = chan_reg.own;
                    end
                end
                ST_PLAY:
                begin
                    if (!scan_in.stop_tier && beats)
                    begin
                        scan_next.has_pick = 1'b1;
                        scan_next.pick     = IDX;
                        scan_next.bp       = chan_reg.pri;
                        scan_next.bt       = chan_reg.own;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
            chan_reg <= '{st: ST_OFF, pri: 8'd0, own: 4'd0};
        end
        else
        begin
            scan_reg <= scan_next;
            if (wr.en && (wr.idx == IDX))
            begin
                chan_reg <= '{st: wr.st, pri: wr.pri, own: wr.own};
            end
        end
    end

endmodule
